// File: hdl/rle_pkg.sv
// Shared types, codes and helper functions for the ring leader election node.
// Used by rle_step and ring_leader_election_node; no dependencies.
`timescale 1ns / 1ps

package rle_pkg;

    localparam int ID_BITS   = 16;
    localparam int MAX_RING  = 1024;
    localparam int TTL_BITS  = 11;
    localparam int PH_BITS   = 4;
    localparam int RING_BITS = 11;
    localparam int TTL_MAX   = 2 * MAX_RING - 1;
    localparam int POW_BITS  = 1 << PH_BITS;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_PROBE  = 2'd1;
    localparam logic [1:0] OP_ECHO   = 2'd2;
    localparam logic [1:0] OP_LEADER = 2'd3;

    localparam logic [1:0] KIND_PROBE  = 2'd0;
    localparam logic [1:0] KIND_ECHO   = 2'd1;
    localparam logic [1:0] KIND_LEADER = 2'd2;

    localparam logic [1:0] ST_CANDIDATE = 2'd0;
    localparam logic [1:0] ST_LOST      = 2'd1;
    localparam logic [1:0] ST_WON       = 2'd2;

    localparam logic LINK_RIGHT = 1'b0;
    localparam logic LINK_LEFT  = 1'b1;

    localparam logic REG_NODE_ID   = 1'b0;
    localparam logic REG_RING_SIZE = 1'b1;

    localparam logic [PH_BITS-1:0] PHASE_MAX = '1;
    localparam logic [1:0]         REPLY_MAX = 2'd3;
    localparam logic [1:0]         REPLY_WIN = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic                arrived_left;
        logic [ID_BITS-1:0]  id;
        logic [PH_BITS-1:0]  phase;
        logic [TTL_BITS-1:0] ttl;
        logic                dir;
    } rle_msg_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [PH_BITS-1:0] phase;
        logic [1:0]         replies;
        logic               over;
    } rle_state_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic                side;
        logic [ID_BITS-1:0]  id;
        logic [PH_BITS-1:0]  phase;
        logic [TTL_BITS-1:0] ttl;
        logic                dir;
        logic                last;
        logic [1:0]          status;
    } rle_result_t;

    function automatic logic [TTL_BITS-1:0] budget(input logic [PH_BITS-1:0] phase);
        logic [POW_BITS:0] b;
        b = (POW_BITS+1)'(1) << phase;
        if (b > (POW_BITS+1)'(TTL_MAX)) begin
            b = (POW_BITS+1)'(TTL_MAX);
        end
        return b[TTL_BITS-1:0];
    endfunction

    function automatic rle_result_t make_result(
        input logic [1:0]          kind,
        input logic                side,
        input logic [ID_BITS-1:0]  id,
        input logic [PH_BITS-1:0]  phase,
        input logic [TTL_BITS-1:0] ttl,
        input logic                dir
    );
        rle_result_t r;
        r.kind   = kind;
        r.side   = side;
        r.id     = id;
        r.phase  = phase;
        r.ttl    = ttl;
        r.dir    = dir;
        r.last   = 1'b0;
        r.status = ST_CANDIDATE;
        return r;
    endfunction

endpackage

// File: hdl/rle_step.sv
// Election step: decodes one registered message against the node state and
// produces the next state plus up to two outgoing items. Depends on rle_pkg.
`timescale 1ns / 1ps

module rle_step (
    input  rle_pkg::rle_msg_t                 msg,
    input  rle_pkg::rle_state_t               state,
    input  logic [rle_pkg::ID_BITS-1:0]       node_id,
    input  logic [rle_pkg::RING_BITS-1:0]     ring_size,
    output rle_pkg::rle_state_t               state_next,
    output logic [1:0]                        res_count,
    output rle_pkg::rle_result_t              res0,
    output rle_pkg::rle_result_t              res1
);

    rle_pkg::rle_state_t         st;
    rle_pkg::rle_result_t        r0;
    rle_pkg::rle_result_t        r1;
    logic [1:0]                  n;
    logic                        own;
    logic [1:0]                  rc;
    logic [rle_pkg::PH_BITS-1:0] new_phase;
    logic [rle_pkg::POW_BITS:0]  pow;
    logic                        win;
    logic                        back;

    assign own = (msg.id == node_id);

    // own probe or echo returning: count a reply, advance the phase on two
    always_comb begin
        rc = (state.replies < rle_pkg::REPLY_MAX) ? state.replies + 2'd1 : state.replies;
        new_phase = (state.phase < rle_pkg::PHASE_MAX) ? state.phase + 1'b1 : state.phase;
        pow = (rle_pkg::POW_BITS+1)'(1) << new_phase;
        win = (pow >= (rle_pkg::POW_BITS+1)'(ring_size));
    end

    always_comb begin
        st   = state;
        n    = 2'd0;
        r0   = rle_pkg::make_result(rle_pkg::KIND_PROBE, rle_pkg::LINK_RIGHT, node_id,
                                    state.phase, rle_pkg::budget(state.phase),
                                    rle_pkg::LINK_RIGHT);
        r1   = rle_pkg::make_result(rle_pkg::KIND_PROBE, rle_pkg::LINK_LEFT, node_id,
                                    state.phase, rle_pkg::budget(state.phase),
                                    rle_pkg::LINK_LEFT);
        back = ~msg.dir;

        if (!state.over) begin
            unique case (msg.op)
                rle_pkg::OP_START: begin
                    n = 2'd2;
                end
                rle_pkg::OP_PROBE, rle_pkg::OP_ECHO: begin
                    if (own) begin
                        if (rc < rle_pkg::REPLY_WIN) begin
                            st.replies = rc;
                        end else begin
                            st.replies = 2'd0;
                            st.phase   = new_phase;
                            n          = 2'd2;
                            if (win) begin
                                st.status = rle_pkg::ST_WON;
                                r0 = rle_pkg::make_result(rle_pkg::KIND_LEADER,
                                    rle_pkg::LINK_LEFT, node_id, '0, '0, 1'b0);
                                r1 = rle_pkg::make_result(rle_pkg::KIND_LEADER,
                                    rle_pkg::LINK_RIGHT, node_id, '0, '0, 1'b0);
                            end else begin
                                r0 = rle_pkg::make_result(rle_pkg::KIND_PROBE,
                                    rle_pkg::LINK_RIGHT, node_id, new_phase,
                                    rle_pkg::budget(new_phase), rle_pkg::LINK_RIGHT);
                                r1 = rle_pkg::make_result(rle_pkg::KIND_PROBE,
                                    rle_pkg::LINK_LEFT, node_id, new_phase,
                                    rle_pkg::budget(new_phase), rle_pkg::LINK_LEFT);
                            end
                        end
                    end else if (msg.op == rle_pkg::OP_ECHO) begin
                        n  = 2'd1;
                        r0 = rle_pkg::make_result(rle_pkg::KIND_ECHO, msg.dir, msg.id,
                                                  msg.phase, '0, msg.dir);
                    end else if (msg.id > node_id) begin
                        n = 2'd1;
                        if (state.status == rle_pkg::ST_CANDIDATE) begin
                            st.status = rle_pkg::ST_LOST;
                        end
                        if (msg.ttl > rle_pkg::TTL_BITS'(1)) begin
                            r0 = rle_pkg::make_result(rle_pkg::KIND_PROBE, msg.dir, msg.id,
                                msg.phase, msg.ttl - rle_pkg::TTL_BITS'(1), msg.dir);
                        end else begin
                            r0 = rle_pkg::make_result(rle_pkg::KIND_ECHO, back, msg.id,
                                                      msg.phase, '0, back);
                        end
                    end
                end
                rle_pkg::OP_LEADER: begin
                    st.over = 1'b1;
                    if (own) begin
                        st.status = rle_pkg::ST_WON;
                    end else begin
                        n  = 2'd1;
                        r0 = rle_pkg::make_result(rle_pkg::KIND_LEADER,
                            msg.arrived_left ? rle_pkg::LINK_RIGHT : rle_pkg::LINK_LEFT,
                            msg.id, '0, '0, 1'b0);
                    end
                end
                default: begin
                    n = 2'd0;
                end
            endcase
        end

        r0.status = st.status;
        r1.status = st.status;
        r0.last   = (n == 2'd1);
        r1.last   = 1'b1;
    end

    assign state_next = st;
    assign res_count  = n;
    assign res0       = r0;
    assign res1       = r1;

endmodule

// File: hdl/ring_leader_election_node.sv
// Top level of one Hirschberg-Sinclair ring election node: input register,
// election step, four-entry result queue and APB register file. Uses rle_pkg, rle_step.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready| tuser operation; tdata message fields, tlast none
//  m_      | out | m_tvalid/m_tready| tuser out_kind; tdata result fields; tlast last
//  apb     | in  | psel/penable     | node_id at 0x0, ring_size at 0x4
//
// An item waits in the input register until the step logic writes its 0, 1 or 2
// results into the queue; each result leaves in its own cycle while m_tready is high,
// and the rate is one item per cycle without results while the queue has room.
// The input register waits while fewer than two queue entries are free.
// aresetn is synchronous and active low; it clears the election state,
// the queue and the registers (node_id 0, ring_size 1).
`timescale 1ns / 1ps

module ring_leader_election_node (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // operation
    input  logic [39:0] s_tdata,   // arrived_left, msg_id, msg_phase, msg_ttl, msg_dir, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // out_kind
    output logic [39:0] m_tdata,   // out_side, out_id, out_phase, out_ttl, out_dir,
                                   // node_status, pad
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QDEPTH = 4;
    localparam int QBITS  = $clog2(QDEPTH);

    logic [rle_pkg::ID_BITS-1:0]   node_id_reg;
    logic [rle_pkg::RING_BITS-1:0] ring_size_reg;

    logic                 in_valid_reg;
    rle_pkg::rle_msg_t    in_msg_reg;
    rle_pkg::rle_msg_t    in_msg_next;
    rle_pkg::rle_state_t  state_reg;
    rle_pkg::rle_state_t  state_next;

    logic [1:0]           res_count;
    rle_pkg::rle_result_t res0;
    rle_pkg::rle_result_t res1;

    rle_pkg::rle_result_t q_mem [QDEPTH];
    logic [QBITS-1:0]     wr_ptr_reg;
    logic [QBITS-1:0]     rd_ptr_reg;
    logic [QBITS:0]       count_reg;
    logic [QBITS:0]       count_next;
    logic [1:0]           push_n;
    logic                 fire;
    logic                 pop;
    logic                 cfg_wr;
    rle_pkg::rle_result_t q_head;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[2])
            rle_pkg::REG_NODE_ID:   prdata = 32'(node_id_reg);
            rle_pkg::REG_RING_SIZE: prdata = 32'(ring_size_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg   <= '0;
            ring_size_reg <= rle_pkg::RING_BITS'(1);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                rle_pkg::REG_NODE_ID:   node_id_reg   <= pwdata[rle_pkg::ID_BITS-1:0];
                rle_pkg::REG_RING_SIZE: ring_size_reg <= pwdata[rle_pkg::RING_BITS-1:0];
                default:                node_id_reg   <= node_id_reg;
            endcase
        end
    end

    // input register
    assign fire     = in_valid_reg && (count_reg <= (QBITS+1)'(QDEPTH - 2));
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_msg_next.op           = s_tuser;
        in_msg_next.arrived_left = s_tdata[0];
        in_msg_next.id           = s_tdata[16:1];
        in_msg_next.phase        = s_tdata[20:17];
        in_msg_next.ttl          = s_tdata[31:21];
        in_msg_next.dir          = s_tdata[32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_msg_reg <= in_msg_next;
        end
    end

    rle_step u_step (
        .msg        (in_msg_reg),
        .state      (state_reg),
        .node_id    (node_id_reg),
        .ring_size  (ring_size_reg),
        .state_next (state_next),
        .res_count  (res_count),
        .res0       (res0),
        .res1       (res1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{status: rle_pkg::ST_CANDIDATE, phase: '0, replies: '0, over: 1'b0};
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // result queue
    assign push_n     = fire ? res_count : 2'd0;
    assign pop        = m_tvalid && m_tready;
    assign count_next = count_reg + (QBITS+1)'(push_n) - (QBITS+1)'(pop);

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            q_mem[wr_ptr_reg + QBITS'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QBITS'(push_n);
            rd_ptr_reg <= rd_ptr_reg + QBITS'(pop);
            count_reg  <= count_next;
        end
    end

    assign q_head   = q_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = q_head.kind;
    assign m_tlast  = q_head.last;
    assign m_tdata  = {5'b0, q_head.status, q_head.dir, q_head.ttl, q_head.phase,
                       q_head.id, q_head.side};

endmodule
